// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on every rising edge of clk_i, switched off while rst_ni is low.
`define USNP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("usnp assertion failed");

// Same-cycle implication.
`define USNP_ASSERT_IMP(lbl, ante, cons) \
  `USNP_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define USNP_ASSERT_NEXT(lbl, ante, cons) \
  `USNP_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== hdl/usnp_pkg.sv =====
// ----------------------------------------------------------------------------
// usnp_pkg
// Shared types and constants of the unit suffix number parser.
// ----------------------------------------------------------------------------
package usnp_pkg;

  localparam int UNIT_CHARS_DEFAULT = 6;
  localparam int WORD_W             = 64;
  localparam int FACTOR_W           = 13;
  localparam int SHIFT_W            = 6;
  localparam int CFG_ADDR_W         = 3;
  localparam int CFG_DATA_W         = 32;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_METRIC_MODE = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_UNRECOGNISED = 2'd1,
    STATUS_MISSING_MULT = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] total;
    logic [1:0]        status;
  } out_item_t;

  // One addend: num * factor << shift, dropped when en is low.
  typedef struct packed {
    logic                en;
    logic [WORD_W-1:0]   num;
    logic [SHIFT_W-1:0]  shift;
    logic [FACTOR_W-1:0] factor;
  } ev_t;

  typedef struct packed {
    ev_t     ev1;
    ev_t     ev2;
    logic    last;
    status_e status;
  } parse_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] prod1;
    logic [WORD_W-1:0] prod2;
    logic              last;
    status_e           status;
  } scaled_item_t;

endpackage

// ===== hdl/usnp_stream_if.sv =====
// ----------------------------------------------------------------------------
// usnp_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface usnp_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== hdl/usnp_parser.sv =====
// ----------------------------------------------------------------------------
// usnp_parser
// Byte scanner: tokenises the text, matches unit words and emits addends.
// ----------------------------------------------------------------------------
module usnp_parser
  import usnp_pkg::*;
#(
  parameter int MaxUnitChars = UNIT_CHARS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mode_i,
  input  logic        in_valid_i,
  input  in_item_t    in_item_i,
  output logic        in_ready_o,
  output logic        item_valid_o,
  output parse_item_t item_o,
  input  logic        item_ready_i
);

  localparam int LenW = $clog2(MaxUnitChars + 2);
  localparam int TextBits = 48;
  localparam int TableSize = 12;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NUM,
    PH_UNIT
  } phase_e;

  typedef struct packed {
    logic [2:0]          len;
    logic [TextBits-1:0] text;
    logic [SHIFT_W-1:0]  shift;
    logic [FACTOR_W-1:0] factor;
  } unit_entry_t;

  typedef unit_entry_t unit_table_t [TableSize];

  typedef struct packed {
    logic                hit;
    logic [SHIFT_W-1:0]  shift;
    logic [FACTOR_W-1:0] factor;
  } unit_hit_t;

  // Words are stored first character in the low byte, hence written reversed.
  localparam unit_table_t STORAGE_UNITS = '{
    '{3'd1, TextBits'("b"),      6'd0,  13'd1},
    '{3'd4, TextBits'("etyb"),   6'd0,  13'd1},
    '{3'd1, TextBits'("k"),      6'd10, 13'd1},
    '{3'd2, TextBits'("bk"),     6'd10, 13'd1},
    '{3'd1, TextBits'("m"),      6'd20, 13'd1},
    '{3'd2, TextBits'("bm"),     6'd20, 13'd1},
    '{3'd1, TextBits'("g"),      6'd30, 13'd1},
    '{3'd2, TextBits'("bg"),     6'd30, 13'd1},
    '{3'd1, TextBits'("t"),      6'd40, 13'd1},
    '{3'd2, TextBits'("bt"),     6'd40, 13'd1},
    '{3'd1, TextBits'("p"),      6'd50, 13'd1},
    '{3'd2, TextBits'("bp"),     6'd50, 13'd1}
  };

  // Seconds as factor << shift: 60 = 15 << 2, 3600 = 225 << 4,
  // 86400 = 675 << 7, 604800 = 4725 << 7.
  localparam unit_table_t DURATION_UNITS = '{
    '{3'd1, TextBits'("s"),      6'd0,  13'd1},
    '{3'd3, TextBits'("ces"),    6'd0,  13'd1},
    '{3'd6, TextBits'("dnoces"), 6'd0,  13'd1},
    '{3'd1, TextBits'("m"),      6'd2,  13'd15},
    '{3'd3, TextBits'("nim"),    6'd2,  13'd15},
    '{3'd6, TextBits'("etunim"), 6'd2,  13'd15},
    '{3'd1, TextBits'("h"),      6'd4,  13'd225},
    '{3'd4, TextBits'("ruoh"),   6'd4,  13'd225},
    '{3'd1, TextBits'("d"),      6'd7,  13'd675},
    '{3'd3, TextBits'("yad"),    6'd7,  13'd675},
    '{3'd1, TextBits'("w"),      6'd7,  13'd4725},
    '{3'd4, TextBits'("keew"),   6'd7,  13'd4725}
  };

  function automatic unit_hit_t match_unit(input logic [MaxUnitChars-1:0][7:0] chars,
                                           input logic [LenW-1:0] len,
                                           input logic mode);
    unit_table_t                  tab;
    logic [MaxUnitChars-1:0][7:0] key;
    unit_hit_t                    res;
    if (mode) begin
      tab = DURATION_UNITS;
    end else begin
      tab = STORAGE_UNITS;
    end
    res = '0;
    // Mask stale bytes left over from earlier, longer units.
    for (int j = 0; j < MaxUnitChars; j++) begin
      key[j] = (LenW'(j) < len) ? chars[j] : 8'h00;
    end
    for (int i = 0; i < TableSize; i++) begin
      if ((LenW'(tab[i].len) == len) && (int'(tab[i].len) <= MaxUnitChars) &&
          (64'(key) == 64'(tab[i].text))) begin
        res.hit    = 1'b1;
        res.shift  = tab[i].shift;
        res.factor = tab[i].factor;
      end
    end
    return res;
  endfunction

  phase_e                       phase_q, phase_d;
  logic [WORD_W-1:0]            acc_q, acc_d;
  logic                         pend_q, pend_d;
  logic [MaxUnitChars-1:0][7:0] uchars_q, uchars_d;
  logic [LenW-1:0]              ulen_q, ulen_d;
  logic                         seen_q, seen_d;
  status_e                      err_q, err_d;
  logic                         item_valid_q;
  parse_item_t                  item_q, item_d;

  logic      in_fire;
  logic [7:0] c;
  logic [3:0] digit;
  unit_hit_t lk_byte, lk_last;

  assign in_ready_o = !item_valid_q || item_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    pend_d   = pend_q;
    uchars_d = uchars_q;
    ulen_d   = ulen_q;
    seen_d   = seen_q;
    err_d    = err_q;
    item_d   = '0;
    c        = in_item_i.ch;
    digit    = 4'(in_item_i.ch - CH_ZERO);
    lk_byte  = match_unit(uchars_q, ulen_q, mode_i);

    if (in_item_i.has_char) begin
      if ((c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]})) begin
        if (phase_d == PH_UNIT) begin
          if (!lk_byte.hit) begin
            err_d = STATUS_UNRECOGNISED;
          end else if (!seen_d) begin
            err_d = STATUS_MISSING_MULT;
          end else begin
            item_d.ev1 = '{1'b1, acc_d, lk_byte.shift, lk_byte.factor};
          end
          seen_d = 1'b1;
          acc_d  = '0;
          pend_d = 1'b0;
        end
        phase_d = PH_IDLE;
      end else if (c inside {[CH_ZERO:CH_NINE]}) begin
        if (phase_d == PH_UNIT) begin
          if (!lk_byte.hit) begin
            err_d = STATUS_UNRECOGNISED;
          end else if (!seen_d) begin
            err_d = STATUS_MISSING_MULT;
          end else begin
            item_d.ev1 = '{1'b1, acc_d, lk_byte.shift, lk_byte.factor};
          end
          seen_d  = 1'b1;
          acc_d   = '0;
          pend_d  = 1'b0;
          phase_d = PH_IDLE;
        end
        if (phase_d != PH_NUM) begin
          // Previous number had no unit: count it once.
          if (pend_d) begin
            item_d.ev1 = '{1'b1, acc_d, SHIFT_W'(0), FACTOR_W'(1)};
          end
          acc_d   = '0;
          pend_d  = 1'b1;
          seen_d  = 1'b1;
          phase_d = PH_NUM;
        end
        acc_d = (acc_d << 3) + (acc_d << 1) + WORD_W'(digit);
      end else begin
        if (phase_d != PH_UNIT) begin
          if (!pend_d) begin
            acc_d = '0;
          end
          pend_d  = 1'b0;
          ulen_d  = '0;
          phase_d = PH_UNIT;
        end
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
          c = c + CASE_SHIFT;
        end
        for (int j = 0; j < MaxUnitChars; j++) begin
          if (ulen_d == LenW'(j)) begin
            uchars_d[j] = c;
          end
        end
        // Saturate one past the limit to mark an over-long unit.
        if (ulen_d <= LenW'(MaxUnitChars)) begin
          ulen_d = ulen_d + LenW'(1);
        end
      end
    end

    lk_last = match_unit(uchars_d, ulen_d, mode_i);

    if (in_item_i.last) begin
      if (phase_d == PH_UNIT) begin
        if (!lk_last.hit) begin
          err_d = STATUS_UNRECOGNISED;
        end else if (!seen_d) begin
          err_d = STATUS_MISSING_MULT;
        end else begin
          item_d.ev2 = '{1'b1, acc_d, lk_last.shift, lk_last.factor};
        end
        pend_d = 1'b0;
      end
      if (pend_d) begin
        item_d.ev2 = '{1'b1, acc_d, SHIFT_W'(0), FACTOR_W'(1)};
      end
      item_d.last   = 1'b1;
      item_d.status = err_d;
      phase_d = PH_IDLE;
      acc_d   = '0;
      pend_d  = 1'b0;
      ulen_d  = '0;
      seen_d  = 1'b0;
      err_d   = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      acc_q        <= '0;
      pend_q       <= 1'b0;
      ulen_q       <= '0;
      seen_q       <= 1'b0;
      err_q        <= STATUS_OK;
      item_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q      <= phase_d;
        acc_q        <= acc_d;
        pend_q       <= pend_d;
        ulen_q       <= ulen_d;
        seen_q       <= seen_d;
        err_q        <= err_d;
        item_valid_q <= 1'b1;
      end else if (item_ready_i) begin
        item_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      uchars_q <= uchars_d;
      item_q   <= item_d;
    end
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

// ===== hdl/usnp_scale.sv =====
// ----------------------------------------------------------------------------
// usnp_scale
// Multiplies each addend by its unit factor and applies the unit shift.
// ----------------------------------------------------------------------------
module usnp_scale
  import usnp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  input  parse_item_t  item_i,
  output logic         item_ready_o,
  output logic         scaled_valid_o,
  output scaled_item_t scaled_o,
  input  logic         scaled_ready_i
);

  function automatic logic [WORD_W-1:0] scale_ev(input ev_t ev);
    logic [WORD_W+FACTOR_W-1:0] full;
    full = ev.num * ev.factor;
    return ev.en ? (full[WORD_W-1:0] << ev.shift) : '0;
  endfunction

  logic         scaled_valid_q;
  scaled_item_t scaled_q, scaled_d;
  logic         fire;

  assign item_ready_o = !scaled_valid_q || scaled_ready_i;
  assign fire         = item_valid_i && item_ready_o;

  always_comb begin
    scaled_d.prod1  = scale_ev(item_i.ev1);
    scaled_d.prod2  = scale_ev(item_i.ev2);
    scaled_d.last   = item_i.last;
    scaled_d.status = item_i.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scaled_valid_q <= 1'b0;
    end else if (fire) begin
      scaled_valid_q <= 1'b1;
    end else if (scaled_ready_i) begin
      scaled_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      scaled_q <= scaled_d;
    end
  end

  assign scaled_valid_o = scaled_valid_q;
  assign scaled_o       = scaled_q;

endmodule

// ===== hdl/usnp_accum.sv =====
// ----------------------------------------------------------------------------
// usnp_accum
// Running sum of scaled addends and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module usnp_accum
  import usnp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         scaled_valid_i,
  input  scaled_item_t scaled_i,
  output logic         scaled_ready_o,
  output logic         out_valid_o,
  output out_item_t    out_o,
  input  logic         out_ready_i
);

  logic [WORD_W-1:0] total_q;
  logic [WORD_W-1:0] sum;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_total_q;
  status_e           out_status_q;
  logic              take;

  // Only the final transfer of a string needs room in the result register.
  assign scaled_ready_o = !scaled_i.last || !out_valid_q || out_ready_i;
  assign take           = scaled_valid_i && scaled_ready_o;
  assign sum            = total_q + scaled_i.prod1 + scaled_i.prod2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        total_q <= scaled_i.last ? '0 : sum;
      end
      if (take && scaled_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && scaled_i.last) begin
      out_total_q  <= (scaled_i.status == STATUS_OK) ? sum : '0;
      out_status_q <= scaled_i.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_o.total  = out_total_q;
  assign out_o.status = out_status_q;

  `USNP_ASSERT_IMP(a_error_zero_total, out_valid_q && (out_status_q != STATUS_OK),
                   out_total_q == '0)
  `USNP_ASSERT_NEXT(a_last_clears_sum, take && scaled_i.last, total_q == '0)
  `USNP_ASSERT_NEXT(a_last_gives_result, take && scaled_i.last, out_valid_q)

endmodule

// ===== hdl/unit_suffix_number_parser.sv =====
// ----------------------------------------------------------------------------
// unit_suffix_number_parser
// Result path: the transfer of the last byte loads the scan register, then the
//   scale register and then the result register take the item in turn.
// Throughput: one byte per cycle; stalls only when a finished result waits
//   in the result register and another string end arrives behind it.
// Reset: asynchronous, clears the parse state (not the stored unit bytes), the running sum and metric_mode.
// ----------------------------------------------------------------------------
module unit_suffix_number_parser
  import usnp_pkg::*;
#(
  parameter int MaxUnitChars = UNIT_CHARS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  usnp_stream_if.sink           in_i,
  usnp_stream_if.source         out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic         metric_mode_q;
  logic         cfg_write;

  logic         parse_valid;
  parse_item_t  parse_item;
  logic         parse_ready;
  logic         scaled_valid;
  scaled_item_t scaled_item;
  logic         scaled_ready;
  in_item_t     in_item;
  out_item_t    out_item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_METRIC_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_mode_q <= 1'b0;
    end else if (cfg_write) begin
      metric_mode_q <= pwdata[0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_METRIC_MODE: prdata = CFG_DATA_W'(metric_mode_q);
      default:         prdata = '0;
    endcase
  end

  assign in_item = in_i.payload;

  usnp_parser #(
    .MaxUnitChars(MaxUnitChars)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (metric_mode_q),
    .in_valid_i  (in_i.valid),
    .in_item_i   (in_item),
    .in_ready_o  (in_i.ready),
    .item_valid_o(parse_valid),
    .item_o      (parse_item),
    .item_ready_i(parse_ready)
  );

  usnp_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (parse_valid),
    .item_i        (parse_item),
    .item_ready_o  (parse_ready),
    .scaled_valid_o(scaled_valid),
    .scaled_o      (scaled_item),
    .scaled_ready_i(scaled_ready)
  );

  usnp_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scaled_valid_i(scaled_valid),
    .scaled_i      (scaled_item),
    .scaled_ready_o(scaled_ready),
    .out_valid_o   (out_o.valid),
    .out_o         (out_item),
    .out_ready_i   (out_o.ready)
  );

  assign out_o.payload = out_item;

endmodule

// ===== tb/sv/unit_suffix_number_parser_tb.sv =====
// ----------------------------------------------------------------------------
// unit_suffix_number_parser_tb
// Streams text one byte per transfer into the suffix parser and checks each
// returned total and status against a software parser kept in step with every
// accepted byte. Both modes are exercised, with random stalls on both sides.
// ----------------------------------------------------------------------------
module unit_suffix_number_parser_tb;
  import usnp_pkg::*;

  typedef byte unsigned text_t[$];

  // Parses the accepted bytes the same way the block should and keeps the
  // totals that are still to come out.
  class suffix_sum_board;
    typedef enum logic [1:0] {SCAN_GAP, SCAN_NUM, SCAN_UNIT} scan_e;

    bit          dur_mode;
    scan_e       phase;
    bit [63:0]   num_acc;
    bit          num_open;
    byte unsigned unit_txt[6];
    int          unit_len;
    bit          any_token;
    bit [63:0]   run_sum;
    status_e     err;
    out_item_t   sums_q[$];
    int          errors;

    function new();
      dur_mode = 1'b0;
      errors   = 0;
      clear();
    endfunction

    static function void unit_entry(input bit dur, input int idx, output string name,
                                    output bit [63:0] mult);
      string     size_n[12] = '{"b", "byte", "k", "kb", "m", "mb", "g", "gb", "t", "tb",
                                "p", "pb"};
      string     dur_n[12]  = '{"s", "sec", "second", "m", "min", "minute", "h", "hour",
                                "d", "day", "w", "week"};
      bit [63:0] dur_m[12]  = '{1, 1, 1, 60, 60, 60, 3600, 3600, 86400, 86400,
                                604800, 604800};
      name = dur ? dur_n[idx] : size_n[idx];
      mult = dur ? dur_m[idx] : 64'd1 << (10 * (idx / 2));
    endfunction

    function void clear();
      phase     = SCAN_GAP;
      num_acc   = '0;
      num_open  = 1'b0;
      unit_len  = 0;
      any_token = 1'b0;
      run_sum   = '0;
      err       = STATUS_OK;
    endfunction

    function void close_unit();
      string     name;
      bit [63:0] m;
      bit [63:0] mult;
      bit        hit;
      bit        same;
      hit  = 1'b0;
      mult = '0;
      if (unit_len <= 6) begin
        for (int i = 0; i < 12; i++) begin
          unit_entry(dur_mode, i, name, m);
          same = (name.len() == unit_len);
          for (int j = 0; same && j < unit_len; j++)
            if (unit_txt[j] != name[j]) same = 1'b0;
          if (same && !hit) begin
            hit  = 1'b1;
            mult = m;
          end
        end
      end
      if (!hit) err = STATUS_UNRECOGNISED;
      else if (!any_token) err = STATUS_MISSING_MULT;
      else run_sum += mult * num_acc;
      any_token = 1'b1;
      num_acc   = '0;
      num_open  = 1'b0;
      phase     = SCAN_GAP;
    endfunction

    function void commit_number();
      if (num_open) run_sum += num_acc;
      num_open = 1'b0;
      num_acc  = '0;
    endfunction

    function void take_item(in_item_t it);
      byte unsigned c;
      out_item_t    res;
      c = it.ch;
      if (it.has_char) begin
        if (c == 32 || (c >= 9 && c <= 13)) begin
          if (phase == SCAN_UNIT) close_unit();
          phase = SCAN_GAP;
        end else if (c >= 48 && c <= 57) begin
          if (phase == SCAN_UNIT) close_unit();
          if (phase != SCAN_NUM) begin
            commit_number();
            num_open  = 1'b1;
            any_token = 1'b1;
            phase     = SCAN_NUM;
          end
          num_acc = num_acc * 10 + 64'(c - 48);
        end else begin
          if (phase != SCAN_UNIT) begin
            // a number directly before the unit stays in num_acc as multiplier
            if (!num_open) num_acc = '0;
            num_open = 1'b0;
            unit_len = 0;
            phase    = SCAN_UNIT;
          end
          if (c >= 65 && c <= 90) c += 32;
          if (unit_len < 6) unit_txt[unit_len] = c;
          if (unit_len <= 6) unit_len++;
        end
      end
      if (it.last) begin
        if (phase == SCAN_UNIT) close_unit();
        commit_number();
        res.total  = (err != STATUS_OK) ? '0 : run_sum;
        res.status = err;
        sums_q.push_back(res);
        clear();
      end
    endfunction

    function void report(string what, bit [63:0] got, bit [63:0] want);
      if (errors < 40)
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
    endfunction

    function void check_sum(out_item_t got);
      out_item_t want;
      if (sums_q.size() == 0) begin
        report("unexpected result total", got.total, '0);
        return;
      end
      want = sums_q.pop_front();
      if (got.total !== want.total) report("total", got.total, want.total);
      if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  usnp_stream_if #(.payload_t(in_item_t))  in_if ();
  usnp_stream_if #(.payload_t(out_item_t)) out_if ();

  unit_suffix_number_parser u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  suffix_sum_board sb;
  bit no_gaps;
  bit hold_req;
  int hold_left;
  int sent;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Observe transfers on both channels.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.take_item(in_if.payload);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_sum(out_if.payload);
  end

  // Receiver: random back-pressure, or a long hold when asked for one.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_gaps || ($urandom_range(99) >= 28);
    end
  end

  // After 39 transfers in a hundred, the sender drops valid before its next byte.
  task automatic push_byte(in_item_t it);
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    if (!no_gaps && $urandom_range(99) < 39) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_text(input text_t txt, input bit use_term);
    in_item_t it;
    for (int i = 0; i < txt.size(); i++) begin
      if ($urandom_range(99) < 4) begin
        // empty item without end of string: adds nothing to the total
        it.ch       = 8'($urandom_range(255));
        it.has_char = 1'b0;
        it.last     = 1'b0;
        push_byte(it);
      end
      it.ch       = txt[i];
      it.has_char = 1'b1;
      it.last     = !use_term && (i == txt.size() - 1);
      push_byte(it);
      sent++;
    end
    if (use_term || txt.size() == 0) begin
      it.ch       = 8'($urandom_range(255));
      it.has_char = 1'b0;
      it.last     = 1'b1;
      push_byte(it);
      sent++;
    end
  endtask

  task automatic send_str(input string s, input bit use_term);
    text_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_text(q, use_term);
  endtask

  // Drain, then write metric_mode and read it back.
  task automatic set_mode(input bit mode);
    in_if.valid <= 1'b0;
    while (sb.sums_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_METRIC_MODE, 2'b00};
    pwdata  <= CFG_DATA_W'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.dur_mode = mode;
    // hold psel high and go straight into the read-back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== CFG_DATA_W'(mode)) sb.report("metric_mode readback", prdata, mode);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic byte unsigned ws_byte();
    int w;
    w = $urandom_range(5);
    return (w == 5) ? 8'd32 : 8'(9 + w);
  endfunction

  // Mostly number/unit pairs with random case and spacing, with some bare
  // numbers, junk units, whitespace runs and raw bytes mixed in.
  function automatic text_t gen_text(bit dur);
    text_t        q;
    string        name;
    bit [63:0]    m;
    int           r;
    int           n;
    byte unsigned c;
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(99);
      if (r < 80) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 4);
        repeat (n) q.push_back(8'(48 + $urandom_range(9)));
      end
      if (r < 65) begin
        if ($urandom_range(2) == 0) q.push_back(ws_byte());
        suffix_sum_board::unit_entry(($urandom_range(3) == 0) ? !dur : dur,
                                     $urandom_range(11), name, m);
        for (int i = 0; i < name.len(); i++) begin
          c = name[i];
          if ($urandom_range(1)) c -= 32;
          q.push_back(c);
        end
      end else if (r >= 80 && r < 90) begin
        repeat ($urandom_range(1, 9)) begin
          do c = 8'($urandom_range(255));
          while ((c >= 48 && c <= 57) || c == 32 || (c >= 9 && c <= 13));
          q.push_back(c);
        end
      end else if (r >= 90 && r < 95) begin
        repeat ($urandom_range(1, 3)) q.push_back(ws_byte());
      end else if (r >= 95) begin
        q.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 60) q.push_back(ws_byte());
    end
    return q;
  endfunction

  initial begin
    text_t q;
    bit    mode;
    sb            = new();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    sent          = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_mode(1'b0);
    q = {};
    send_text(q, 1'b1);            // empty string
    send_str("7pB", 1'b0);         // mixed case, largest storage unit
    send_str("k", 1'b0);           // unit with nothing before it
    send_str("5z", 1'b0);          // unknown unit
    send_str("abcdefg", 1'b0);     // over-long unit, also first
    q = '{8'h00, 8'hff};
    send_text(q, 1'b0);            // extreme bytes form a unit
    send_str("3k m", 1'b0);        // unit straight after a unit
    send_str(" \t", 1'b0);         // whitespace only
    set_mode(1'b1);
    send_str("1H\t", 1'b0);

    for (int p = 0; p < 8; p++) begin
      mode = p[0] ^ ((p >= 4) ? 1'($urandom_range(1)) : 1'b0);
      set_mode(mode);
      no_gaps = (p == 2);
      if (p == 4) hold_req = 1'b1;
      sent = 0;
      while (sent < 175) begin
        q = gen_text(mode);
        send_text(q, $urandom_range(9) == 0);
      end
    end

    in_if.valid <= 1'b0;
    while (sb.sums_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.sums_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
